[hw/rtl/hlcd_pkg.sv]
// ----------------------------------------------------------------------------
// hlcd_pkg
// shared types and constants of the header / length / checksum deframer
// ----------------------------------------------------------------------------
package hlcd_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;   // default payload capacity
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 7;    // payload length field
    localparam int APB_AW          = 3;    // one 32-bit register at byte 0
    localparam int APB_DW          = 32;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

    // register word index (paddr bit above the byte offset)
    localparam logic REG_HEADER = 1'b0;

    // receive phase of the front parser
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2,
        PH_CHECK  = 2'd3
    } phase_t;

    // emitter state of the back end
    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SHOW = 1'b1
    } back_state_t;

    // one validated frame waiting to be emitted
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
    } desc_t;

    // queue status seen by front and back
    typedef struct packed {
        logic  full;
        logic  empty;
        desc_t head;
    } queue_status_t;

endpackage

[hw/rtl/hlcd_ifs.sv]
// ----------------------------------------------------------------------------
// hlcd channel interfaces
// valid / ready channels for received bytes and emitted payload words
// ----------------------------------------------------------------------------
interface hlcd_rx_if;
    logic                         valid;
    logic                         ready;
    logic [hlcd_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hlcd_pl_if;
    logic                         valid;
    logic                         ready;
    logic [hlcd_pkg::BYTE_W-1:0]  payload_byte;
    logic [hlcd_pkg::LEN_W-1:0]   payload_length;
    logic                         is_last;

    modport source (output valid, output payload_byte, output payload_length,
                    output is_last, input ready);
    modport sink   (input valid, input payload_byte, input payload_length,
                    input is_last, output ready);
endinterface

[hw/rtl/hlcd_ram.sv]
// ----------------------------------------------------------------------------
// hlcd_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hlcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/hlcd_front.sv]
// ----------------------------------------------------------------------------
// hlcd_front
// frame parser: header hunt, length check, payload store and sum-8 check
// ----------------------------------------------------------------------------
module hlcd_front #(
    parameter int MAX_PAYLOAD = hlcd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    hlcd_rx_if.sink                               rx,
    input  logic [hlcd_pkg::BYTE_W-1:0]           header,
    input  hlcd_pkg::queue_status_t               qstat,
    output logic                                  push,
    output hlcd_pkg::desc_t                       push_desc,
    output logic                                  ram_we,
    output logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1):0] ram_waddr,
    output logic [hlcd_pkg::BYTE_W-1:0]           ram_wdata
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [hlcd_pkg::BYTE_W-1:0] MAX_B = hlcd_pkg::BYTE_W'(MAX_PAYLOAD);

    hlcd_pkg::phase_t                   phase_reg, phase_next;
    logic [hlcd_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [hlcd_pkg::LEN_W-1:0]         idx_reg, idx_next;
    logic [hlcd_pkg::BYTE_W-1:0]        sum_reg, sum_next;
    logic                               bank_reg, bank_next;
    logic                               accept;
    logic [hlcd_pkg::LEN_W-1:0]         idx_inc;
    logic                               sum_match;

    assign accept    = rx.valid & rx.ready;
    assign idx_inc   = idx_reg + hlcd_pkg::LEN_W'(1);
    assign sum_match = (rx.rx_byte == sum_reg) && (len_reg != '0);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                hlcd_pkg::PH_HEADER:
                begin
                    if (rx.rx_byte == header)
                    begin
                        phase_next = hlcd_pkg::PH_LENGTH;
                    end
                end
                hlcd_pkg::PH_LENGTH:
                begin
                    if (rx.rx_byte > MAX_B)
                    begin
                        phase_next = hlcd_pkg::PH_HEADER;
                    end
                    else if (rx.rx_byte == '0)
                    begin
                        phase_next = hlcd_pkg::PH_CHECK;
                    end
                    else
                    begin
                        phase_next = hlcd_pkg::PH_DATA;
                    end
                end
                hlcd_pkg::PH_DATA:
                begin
                    if (idx_inc >= len_reg)
                    begin
                        phase_next = hlcd_pkg::PH_CHECK;
                    end
                end
                hlcd_pkg::PH_CHECK:
                begin
                    phase_next = hlcd_pkg::PH_HEADER;
                end
                default:
                begin
                    phase_next = hlcd_pkg::PH_HEADER;
                end
            endcase
        end
    end

    // outputs: stall payload bytes while both banks are taken
    always_comb
    begin
        rx.ready  = 1'b1;
        ram_we    = 1'b0;
        push      = 1'b0;
        case (phase_reg)
            hlcd_pkg::PH_DATA:
            begin
                rx.ready = ~qstat.full;
                ram_we   = accept;
            end
            hlcd_pkg::PH_CHECK:
            begin
                push = accept & sum_match;
            end
            default:
            begin
                rx.ready = 1'b1;
            end
        endcase
    end

    assign ram_waddr      = {bank_reg, idx_reg[IDX_W-1:0]};
    assign ram_wdata      = rx.rx_byte;
    assign push_desc.bank = bank_reg;
    assign push_desc.len  = len_reg;

    // frame datapath
    always_comb
    begin
        len_next  = len_reg;
        idx_next  = idx_reg;
        sum_next  = sum_reg;
        bank_next = bank_reg;
        if (accept && (phase_reg == hlcd_pkg::PH_LENGTH))
        begin
            idx_next = '0;
            sum_next = '0;
            len_next = (rx.rx_byte > MAX_B) ? '0 : rx.rx_byte[hlcd_pkg::LEN_W-1:0];
        end
        else if (accept && (phase_reg == hlcd_pkg::PH_DATA))
        begin
            idx_next = idx_inc;
            sum_next = sum_reg + rx.rx_byte;
        end
        if (push)
        begin
            bank_next = ~bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hlcd_pkg::PH_HEADER;
            len_reg   <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

[hw/rtl/hlcd_desc_fifo.sv]
// ----------------------------------------------------------------------------
// hlcd_desc_fifo
// two-entry queue of validated frames; head is released after its last word
// ----------------------------------------------------------------------------
module hlcd_desc_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  hlcd_pkg::desc_t          push_desc,
    input  logic                     pop,
    output hlcd_pkg::queue_status_t  qstat
);

    hlcd_pkg::desc_t entry_reg [2];
    logic            wptr_reg, wptr_next;
    logic            rptr_reg, rptr_next;
    logic [1:0]      count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    assign qstat.full  = count_reg[1];
    assign qstat.empty = (count_reg == '0);
    assign qstat.head  = entry_reg[rptr_reg];

endmodule

[hw/rtl/hlcd_back.sv]
// ----------------------------------------------------------------------------
// hlcd_back
// payload emitter: reads a queued frame from its bank and sends it word by word
// ----------------------------------------------------------------------------
module hlcd_back #(
    parameter int MAX_PAYLOAD = hlcd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hlcd_pkg::queue_status_t               qstat,
    output logic                                  pop,
    output logic                                  ram_re,
    output logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1):0] ram_raddr,
    input  logic [hlcd_pkg::BYTE_W-1:0]           ram_rdata,
    hlcd_pl_if.source                             pl
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    hlcd_pkg::back_state_t           state_reg, state_next;
    logic [hlcd_pkg::LEN_W-1:0]      idx_reg, idx_next;
    logic [hlcd_pkg::LEN_W-1:0]      idx_inc;
    logic                            last;
    logic                            sent;

    assign idx_inc = idx_reg + hlcd_pkg::LEN_W'(1);
    assign last    = (idx_reg == (qstat.head.len - hlcd_pkg::LEN_W'(1)));
    assign sent    = pl.valid & pl.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hlcd_pkg::BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = hlcd_pkg::BK_SHOW;
                end
            end
            hlcd_pkg::BK_SHOW:
            begin
                if (sent && last)
                begin
                    state_next = hlcd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = hlcd_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs; the read issued with a handshake lands in the ram output
    // register at the same edge, so words can follow back to back
    always_comb
    begin
        pl.valid  = 1'b0;
        pop       = 1'b0;
        ram_re    = 1'b0;
        idx_next  = idx_reg;
        ram_raddr = {qstat.head.bank, idx_reg[IDX_W-1:0]};
        case (state_reg)
            hlcd_pkg::BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = {qstat.head.bank, {IDX_W{1'b0}}};
                    idx_next  = '0;
                end
            end
            hlcd_pkg::BK_SHOW:
            begin
                pl.valid = 1'b1;
                if (sent)
                begin
                    if (last)
                    begin
                        pop = 1'b1;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = {qstat.head.bank, idx_inc[IDX_W-1:0]};
                        idx_next  = idx_inc;
                    end
                end
            end
            default:
            begin
                pl.valid = 1'b0;
            end
        endcase
    end

    assign pl.payload_byte   = ram_rdata;
    assign pl.payload_length = qstat.head.len;
    assign pl.is_last        = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hlcd_pkg::BK_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

[hw/rtl/header_length_checksum_deframer.sv]
// ----------------------------------------------------------------------------
// header_length_checksum_deframer
// receives header / length / payload / sum-8 frames and emits checked payloads
// ----------------------------------------------------------------------------
//   channel   dir   handshake        word contents
//   rx        in    valid / ready    rx_byte
//   payload   out   valid / ready    payload_byte, payload_length, is_last
//   apb       in    psel / penable   header_byte register at byte address 0
//
// one received word is taken per cycle; payload words stall only while both
//   payload banks still hold frames that wait to be sent
// a checked frame is queued after its checksum word; the emitter reads its first
//   word from its bank, then sends one word per cycle while payload ready is high
// reset is asynchronous; it clears phase, counters and queue and sets header to 0xAA
// stalls on the payload side never block header, length or checksum words
// ----------------------------------------------------------------------------
module header_length_checksum_deframer #(
    parameter int MAX_PAYLOAD = hlcd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    hlcd_rx_if.sink                       rx,
    hlcd_pl_if.source                     payload,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hlcd_pkg::APB_AW-1:0]   paddr,
    input  logic [hlcd_pkg::APB_DW-1:0]   pwdata,
    output logic [hlcd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // payload index width and two-bank ram size
    localparam int IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int RAM_DEPTH = 2 * (2 ** IDX_W);

    // configuration register
    logic [hlcd_pkg::BYTE_W-1:0] header_reg, header_next;
    logic                        cfg_write;
    logic                        reg_sel;

    // front to back plumbing
    hlcd_pkg::queue_status_t     qstat;
    hlcd_pkg::desc_t             push_desc;
    logic                        push;
    logic                        pop;
    logic                        ram_we;
    logic [IDX_W:0]              ram_waddr;
    logic [hlcd_pkg::BYTE_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [IDX_W:0]              ram_raddr;
    logic [hlcd_pkg::BYTE_W-1:0] ram_rdata;

    // apb: zero wait state, word index sits above the byte offset
    assign pready    = 1'b1;
    assign reg_sel   = paddr[hlcd_pkg::APB_AW-1];
    assign cfg_write = psel & penable & pwrite & pready & (reg_sel == hlcd_pkg::REG_HEADER);

    always_comb
    begin
        header_next = header_reg;
        if (cfg_write)
        begin
            header_next = pwdata[hlcd_pkg::BYTE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == hlcd_pkg::REG_HEADER)
        begin
            prdata = {{(hlcd_pkg::APB_DW - hlcd_pkg::BYTE_W){1'b0}}, header_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= hlcd_pkg::HEADER_RESET;
        end
        else
        begin
            header_reg <= header_next;
        end
    end

    // parser: writes payload into the free bank, queues checked frames
    hlcd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .header    (header_reg),
        .qstat     (qstat),
        .push      (push),
        .push_desc (push_desc),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    // frame queue; its occupancy is also the number of banks in use
    hlcd_desc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .qstat     (qstat)
    );

    // payload store, one bank per queued frame
    hlcd_ram #(
        .WIDTH (hlcd_pkg::BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // emitter
    hlcd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .pop       (pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .pl        (payload)
    );

endmodule
